/* rtl/bhir_pkg.sv */
package bhir_pkg;

	// Heap geometry.
	localparam int CAPACITY  = 1024;
	localparam int KEY_WIDTH = 32;
	// A one-based tree position (and the entry count) ranges over 0 .. CAPACITY.
	localparam int POS_W     = $clog2(CAPACITY + 1);
	localparam int ADDR_W    = $clog2(CAPACITY);
	// Result transaction: key, valid flag, count and status, padded to whole bytes.
	localparam int RES_W     = KEY_WIDTH + 1 + POS_W + 1;
	localparam int OUT_W     = ((RES_W + 7) / 8) * 8;

	// Configuration register indexes.
	localparam logic REG_MIN_FIRST = 1'b0;

	// Operation codes carried in tuser.
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_REPLACE = 1'b1;

	// Controller states.
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_UP_RD = 6'b000010,
		S_UP_EV = 6'b000100,
		S_DN_RD = 6'b001000,
		S_DN_EV = 6'b010000,
		S_EMIT  = 6'b100000
	} bhir_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic up_rd;
		logic up_ev;
		logic dn_rd;
		logic dn_ev;
		logic emit;
	} bhir_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic do_ins;
		logic full;
		logic up_at_root;
		logic up_move;
		logic up_next_root;
		logic dn_leaf;
		logic dn_next_leaf;
		logic out_busy;
	} bhir_sts_t;

endpackage

/* rtl/bhir_ctrl.sv */
module bhir_ctrl import bhir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bhir_sts_t sts,
	output bhir_cmd_t cmd
);

	bhir_state_t state_q;
	bhir_state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.do_ins && sts.full) begin
						state_d = S_EMIT;
					end else if (sts.do_ins) begin
						state_d = S_UP_RD;
					end else begin
						state_d = S_DN_RD;
					end
				end
			end
			S_UP_RD: begin
				// At the root the key is written here; otherwise the parent is fetched.
				cmd.up_rd = 1'b1;
				state_d = sts.up_at_root ? S_EMIT : S_UP_EV;
			end
			S_UP_EV: begin
				cmd.up_ev = 1'b1;
				if (!sts.up_move) begin
					state_d = S_EMIT;
				end else if (sts.up_next_root) begin
					state_d = S_UP_RD;
				end
			end
			S_DN_RD: begin
				cmd.dn_rd = 1'b1;
				state_d = sts.dn_leaf ? S_UP_RD : S_DN_EV;
			end
			S_DN_EV: begin
				cmd.dn_ev = 1'b1;
				if (sts.dn_next_leaf) begin
					state_d = S_UP_RD;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/bhir_dp.sv */
module bhir_dp import bhir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bhir_cmd_t            cmd,
	output bhir_sts_t            sts,
	input  logic                 min_first,
	input  logic                 mode,
	input  logic [KEY_WIDTH-1:0] key_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KEY_WIDTH-1:0] out_top_key,
	output logic                 out_top_valid,
	output logic [POS_W-1:0]     out_fill_count,
	output logic                 out_status
);

	// Heap storage, position 1 at address 0.
	logic [KEY_WIDTH-1:0] mem_q [CAPACITY];
	logic [KEY_WIDTH-1:0] rda_q;
	logic [KEY_WIDTH-1:0] rdb_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] root_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     count_q;
	logic                 status_q;

	logic [KEY_WIDTH-1:0] top_key_q;
	logic                 top_valid_q;
	logic [POS_W-1:0]     fill_q;
	logic                 out_status_q;
	logic                 out_valid_q;

	logic [ADDR_W-1:0]    ra;
	logic [ADDR_W-1:0]    rb;
	logic [ADDR_W-1:0]    wa;
	logic                 we;
	logic [KEY_WIDTH-1:0] wd;

	logic [POS_W:0]       left_pos;
	logic [POS_W:0]       right_pos;
	logic [POS_W:0]       next_left;
	logic [POS_W-1:0]     pick_pos;
	logic                 has_right;
	logic                 pick_right;

	// True when a must sit strictly above b in the current order.
	function automatic logic ranks_above(input logic mf, input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b);
		return mf ? (a < b) : (a > b);
	endfunction

	// Memory address of a one-based position.
	function automatic logic [ADDR_W-1:0] to_addr(input logic [POS_W:0] p);
		logic [POS_W:0] t;
		t = p - 1'b1;
		return t[ADDR_W-1:0];
	endfunction

	// Child selection for the hole walking down; the right child wins ties.
	assign left_pos   = {pos_q, 1'b0};
	assign right_pos  = left_pos + 1'b1;
	assign has_right  = right_pos <= {1'b0, count_q};
	assign pick_right = has_right && !ranks_above(min_first, rda_q, rdb_q);
	assign pick_pos   = pick_right ? right_pos[POS_W-1:0] : left_pos[POS_W-1:0];
	assign next_left  = {pick_pos, 1'b0};

	// Status for the controller.
	always_comb begin
		sts.do_ins       = (mode == OP_INSERT) || (count_q == '0);
		sts.full         = count_q >= POS_W'(CAPACITY);
		sts.up_at_root   = pos_q == POS_W'(1);
		sts.up_move      = ranks_above(min_first, key_q, rda_q);
		sts.up_next_root = pos_q[POS_W-1:1] == (POS_W-1)'(1);
		sts.dn_leaf      = left_pos > {1'b0, count_q};
		sts.dn_next_leaf = next_left > {1'b0, count_q};
		sts.out_busy     = out_valid_q && !out_ready;
	end

	// Read addresses for the next level, issued while the current level is resolved.
	always_comb begin
		if (cmd.dn_rd) begin
			ra = to_addr(left_pos);
			rb = to_addr(right_pos);
		end else if (cmd.dn_ev) begin
			ra = to_addr(next_left);
			rb = to_addr(next_left + 1'b1);
		end else if (cmd.up_ev) begin
			ra = to_addr({3'b000, pos_q[POS_W-1:2]});
			rb = ra;
		end else begin
			ra = to_addr({2'b00, pos_q[POS_W-1:1]});
			rb = ra;
		end
	end

	// Write port: one entry settles per level.
	always_comb begin
		we = 1'b0;
		wa = to_addr({1'b0, pos_q});
		wd = key_q;
		if (cmd.up_rd && sts.up_at_root) begin
			we = 1'b1;
		end
		if (cmd.up_ev) begin
			we = 1'b1;
			wd = sts.up_move ? rda_q : key_q;
		end
		if (cmd.dn_ev) begin
			we = 1'b1;
			wd = pick_right ? rdb_q : rda_q;
		end
	end

	// Heap memory with registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rda_q <= mem_q[ra];
		rdb_q <= mem_q[rb];
	end

	// Copy of the root entry, kept so the result needs no extra read.
	always_ff @(posedge clk) begin
		if (we && pos_q == POS_W'(1)) begin
			root_q <= wd;
		end
	end

	// Operation registers and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pos_q    <= '0;
			status_q <= 1'b0;
			key_q    <= '0;
		end else begin
			if (cmd.load) begin
				key_q    <= key_in;
				status_q <= sts.do_ins && sts.full;
				if (sts.do_ins) begin
					if (!sts.full) begin
						count_q <= count_q + 1'b1;
						pos_q   <= count_q + 1'b1;
					end
				end else begin
					pos_q <= POS_W'(1);
				end
			end
			if (cmd.up_ev && sts.up_move) begin
				pos_q <= {1'b0, pos_q[POS_W-1:1]};
			end
			if (cmd.dn_ev) begin
				pos_q <= pick_pos;
			end
		end
	end

	// Output register for the result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			top_key_q    <= (count_q != '0) ? root_q : '0;
			top_valid_q  <= count_q != '0;
			fill_q       <= count_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_top_key    = top_key_q;
	assign out_top_valid  = top_valid_q;
	assign out_fill_count = fill_q;
	assign out_status     = out_status_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= POS_W'(CAPACITY))
		else $error("entry count above capacity");

	// The count changes only when an operation is taken.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load |=> $stable(count_q))
		else $error("entry count changed outside an operation");

	// The hole moves strictly deeper on each step down.
	a_hole_deeper: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_ev |=> pos_q > $past(pos_q))
		else $error("hole did not move down");

	// A promoted parent moves the key one level up.
	a_sift_up: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_ev && sts.up_move |=> pos_q == ($past(pos_q) >> 1))
		else $error("sift up did not move to the parent");

endmodule

/* rtl/binary_heap_insert_replace_top.sv */
// Binary heap priority queue of up to 1024 unsigned 32-bit keys. Each input
// transaction carries a key in tdata and an operation in tuser: 0 inserts the key,
// 1 replaces the top entry with it (on an empty heap it inserts). Each operation
// returns one result transaction with the key now on top (zero when empty), a valid
// flag, the entry count and a status bit that is set when an insert finds the heap
// full. The min_first register at address 0 selects smallest-on-top (1) or
// largest-on-top (0); write it only while the block is idle. One operation is
// handled at a time. An insert that finds the heap full is rejected without touching
// the heap; otherwise the key rises level by level from the new last position. A
// replace-top first lets the hole sink from the root to a leaf and then lets the key
// rise from there. Each level is handled by a read-compare-write step on the heap
// memory, and the result waits while the result side is not ready.
// No clearing pass is needed after reset.
module binary_heap_insert_replace_top import bhir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [KEY_WIDTH-1:0] s_tdata,  // [31:0] key
	input  logic                 s_tuser,  // [0] mode
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata   // [31:0] top_key, [32] top_valid,
	                                       // [43:33] fill_count, [44] status, rest zero
);

	logic                 min_first_q;
	bhir_cmd_t            cmd;
	bhir_sts_t            sts;
	logic [KEY_WIDTH-1:0] top_key;
	logic                 top_valid;
	logic [POS_W-1:0]     fill_count;
	logic                 status;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_FIRST) ? {31'b0, min_first_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_first_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_FIRST) begin
			min_first_q <= pwdata[0];
		end
	end

	bhir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bhir_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.min_first      (min_first_q),
		.mode           (s_tuser),
		.key_in         (s_tdata),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_top_key    (top_key),
		.out_top_valid  (top_valid),
		.out_fill_count (fill_count),
		.out_status     (status)
	);

	// Pack the result transaction.
	assign m_tdata = {(OUT_W - RES_W)'(0), status, fill_count, top_valid, top_key};

endmodule
